### rtl/core/ptrh_pkg.sv
`default_nettype none

package ptrh_pkg;

    localparam int CalWidth   = 16;
    localparam int CalCount   = 6;
    localparam int CfgIdxW    = 3;
    localparam int KindWidth  = 2;
    localparam int RawWidth   = 24;
    localparam int ValWidth   = 32;
    localparam int DtWidth    = 25;
    localparam int OffWidth   = 40;
    localparam int MulAWidth  = 36;
    localparam int ChunkWidth = 8;
    localparam int ChunkIdxW  = 2;
    localparam int ProdWidth  = MulAWidth + ChunkWidth + 1;
    localparam int AccWidth   = 64;

    // Temperature and humidity constants, in hundredths
    localparam logic [ValWidth-1:0]         TempBase    = 32'd2000;
    localparam logic [ValWidth-1:0]         HumOffset   = 32'd600;
    localparam logic signed [MulAWidth-1:0] HumScale    = 36'sd12500;

    // Shift amounts for the divisions by powers of two
    localparam int unsigned TempShift = 23;
    localparam int unsigned OffShift  = 6;
    localparam int unsigned SensShift = 7;
    localparam int unsigned ProdShift = 21;
    localparam int unsigned PresShift = 15;
    localparam int unsigned HumShift  = 16;

    typedef enum logic [KindWidth-1:0] {
        KIND_TEMP = 2'd0,
        KIND_PRES = 2'd1,
        KIND_HUM  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CalWidth-1:0] c1;
        logic [CalWidth-1:0] c2;
        logic [CalWidth-1:0] c3;
        logic [CalWidth-1:0] c4;
        logic [CalWidth-1:0] c5;
        logic [CalWidth-1:0] c6;
    } t_cal;

    typedef struct packed {
        logic                 step;
        logic                 clear;
        logic [ChunkIdxW-1:0] chunk;
    } t_mac_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_MUL_T,
        ST_TFIN,
        ST_MUL_OFF,
        ST_OFF,
        ST_MUL_SENS,
        ST_SENS,
        ST_MUL_P,
        ST_P1,
        ST_P2,
        ST_MUL_H,
        ST_HFIN,
        ST_DONE
    } t_state;

    // Signed shift right that rounds toward zero, like C integer division
    function automatic logic signed [AccWidth-1:0] trunc_shr(
        input logic signed [AccWidth-1:0] x,
        input int unsigned                k
    );
        logic [AccWidth-1:0]        ones;
        logic signed [AccWidth-1:0] bias;
        ones = (AccWidth'(1) << k) - AccWidth'(1);
        bias = x[AccWidth-1] ? $signed(ones) : '0;
        return (x + bias) >>> k;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ptrh_cfg.sv
`default_nettype none

module ptrh_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptrh_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [ptrh_pkg::CalWidth-1:0] i_cfg_data,
    output ptrh_pkg::t_cal                     o_cal
);
    import ptrh_pkg::*;

    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            // indexes past the last word are dropped
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_C1:  r_cal.c1 <= i_cfg_data;
                CFG_C2:  r_cal.c2 <= i_cfg_data;
                CFG_C3:  r_cal.c3 <= i_cfg_data;
                CFG_C4:  r_cal.c4 <= i_cfg_data;
                CFG_C5:  r_cal.c5 <= i_cfg_data;
                CFG_C6:  r_cal.c6 <= i_cfg_data;
                default: r_cal <= r_cal;
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire

### rtl/core/ptrh_mac.sv
`default_nettype none

module ptrh_mac (
    input  wire logic                                 i_clk,
    input  wire ptrh_pkg::t_mac_ctl                   i_ctl,
    input  wire logic signed [ptrh_pkg::MulAWidth-1:0] i_a,
    input  wire logic [ptrh_pkg::RawWidth-1:0]        i_b,
    output logic signed [ptrh_pkg::AccWidth-1:0]      o_acc
);
    import ptrh_pkg::*;

    localparam int BExtWidth = ChunkWidth * (2 ** ChunkIdxW);

    logic [BExtWidth-1:0]        w_b_ext;
    logic [ChunkWidth-1:0]       w_chunk;
    logic signed [ProdWidth-1:0] w_prod;
    logic signed [AccWidth-1:0]  w_base;
    logic signed [AccWidth-1:0]  r_acc;

    assign w_b_ext = {{(BExtWidth - RawWidth){1'b0}}, i_b};
    assign w_chunk = w_b_ext[i_ctl.chunk * ChunkWidth +: ChunkWidth];
    assign w_prod  = i_a * $signed({1'b0, w_chunk});
    // chunks arrive most significant first: shift the partial sum up a chunk
    assign w_base  = i_ctl.clear ? '0 : (r_acc <<< ChunkWidth);

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_acc <= w_base + {{(AccWidth - ProdWidth){w_prod[ProdWidth-1]}}, w_prod};
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

### rtl/core/pt_rh_sensor_compensation.sv
// One item at a time: the next item is taken once the result has moved to the
// output register; the shared 36x8 multiply-accumulate unit is stepped a byte at a time.
// Synchronous active-low reset clears the calibration words, the kept dT,
// the sequencer and the output valid.
`default_nettype none

module pt_rh_sensor_compensation (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ptrh_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [ptrh_pkg::CalWidth-1:0]  i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [ptrh_pkg::KindWidth-1:0] i_action,
    input  wire logic [ptrh_pkg::RawWidth-1:0]  i_raw_reading,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [ptrh_pkg::KindWidth-1:0]      o_reading_kind,
    output logic signed [ptrh_pkg::ValWidth-1:0] o_compensated_value
);
    import ptrh_pkg::*;

    t_cal                       w_cal;
    t_mac_ctl                   w_mac_ctl;
    logic signed [MulAWidth-1:0] w_mul_a;
    logic [RawWidth-1:0]        w_mul_b;
    logic signed [AccWidth-1:0] w_acc;

    t_state                     r_state, n_state;
    logic [ChunkIdxW-1:0]       r_cnt, n_cnt;
    logic                       r_first, n_first;
    logic signed [DtWidth-1:0]  r_dt, n_dt;
    logic                       r_out_valid, n_out_valid;

    logic [KindWidth-1:0]       r_kind, n_kind;
    logic [RawWidth-1:0]        r_raw, n_raw;
    logic signed [OffWidth-1:0] r_off, n_off;
    logic signed [MulAWidth-1:0] r_sens, n_sens;
    logic signed [AccWidth-1:0] r_tmp, n_tmp;
    logic [ValWidth-1:0]        r_res, n_res;
    logic [KindWidth-1:0]       r_out_kind, n_out_kind;
    logic [ValWidth-1:0]        r_out_val, n_out_val;

    logic                       w_accept;
    logic signed [DtWidth-1:0]  w_dt_new;
    logic signed [MulAWidth-1:0] w_dt_ext;
    logic signed [AccWidth-1:0] w_t_q;
    logic signed [AccWidth-1:0] w_off_full;
    logic signed [AccWidth-1:0] w_sens_full;
    logic signed [AccWidth-1:0] w_p1;
    logic signed [AccWidth-1:0] w_p_q;
    logic signed [AccWidth-1:0] w_h_q;

    ptrh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (w_cal)
    );

    ptrh_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_acc (w_acc)
    );

    assign w_accept = i_in_valid && o_in_ready;
    assign w_dt_new = $signed({1'b0, r_raw}) - $signed({1'b0, w_cal.c5, 8'b0});
    assign w_dt_ext = {{(MulAWidth - DtWidth){r_dt[DtWidth-1]}}, r_dt};

    assign w_t_q       = trunc_shr(w_acc, TempShift);
    assign w_off_full  = $signed({31'b0, w_cal.c2, 17'b0}) + trunc_shr(w_acc, OffShift);
    assign w_sens_full = $signed({32'b0, w_cal.c1, 16'b0}) + trunc_shr(w_acc, SensShift);
    assign w_p1        = trunc_shr(w_acc, ProdShift)
                       - {{(AccWidth - OffWidth){r_off[OffWidth-1]}}, r_off};
    assign w_p_q       = trunc_shr(r_tmp, PresShift);
    assign w_h_q       = w_acc >>> HumShift;

    // Multiplier operands per step
    always_comb begin
        w_mul_a = w_dt_ext;
        w_mul_b = '0;
        unique case (r_state)
            ST_MUL_T: begin
                w_mul_b = {8'b0, w_cal.c6};
            end
            ST_MUL_OFF: begin
                w_mul_b = {8'b0, w_cal.c4};
            end
            ST_MUL_SENS: begin
                w_mul_b = {8'b0, w_cal.c3};
            end
            ST_MUL_P: begin
                w_mul_a = r_sens;
                w_mul_b = r_raw;
            end
            ST_MUL_H: begin
                // status bits dropped, upper byte ignored
                w_mul_a = HumScale;
                w_mul_b = {8'b0, r_raw[15:2], 2'b00};
            end
            default: begin
                w_mul_a = w_dt_ext;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_dt        = r_dt;
        n_kind      = r_kind;
        n_raw       = r_raw;
        n_off       = r_off;
        n_sens      = r_sens;
        n_tmp       = r_tmp;
        n_res       = r_res;
        n_out_kind  = r_out_kind;
        n_out_val   = r_out_val;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = (r_state == ST_IDLE);

        w_mac_ctl.step  = 1'b0;
        w_mac_ctl.clear = r_first;
        w_mac_ctl.chunk = r_cnt;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_kind  = i_action;
                    n_raw   = i_raw_reading;
                    n_first = 1'b1;
                    n_cnt   = ChunkIdxW'(1);
                    unique case (t_kind'(i_action))
                        KIND_TEMP: n_state = ST_DT;
                        KIND_PRES: n_state = ST_MUL_OFF;
                        KIND_HUM:  n_state = ST_MUL_H;
                        KIND_NONE: begin
                            n_res   = '0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DT: begin
                n_dt    = w_dt_new;
                n_state = ST_MUL_T;
            end
            ST_MUL_T, ST_MUL_OFF, ST_MUL_SENS, ST_MUL_P, ST_MUL_H: begin
                w_mac_ctl.step = 1'b1;
                n_first        = 1'b0;
                n_cnt          = r_cnt - ChunkIdxW'(1);
                if (r_cnt == '0) begin
                    unique case (r_state)
                        ST_MUL_T:    n_state = ST_TFIN;
                        ST_MUL_OFF:  n_state = ST_OFF;
                        ST_MUL_SENS: n_state = ST_SENS;
                        ST_MUL_P:    n_state = ST_P1;
                        default:     n_state = ST_HFIN;
                    endcase
                end
            end
            ST_TFIN: begin
                n_res   = w_t_q[ValWidth-1:0] + TempBase;
                n_state = ST_DONE;
            end
            ST_OFF: begin
                n_off   = w_off_full[OffWidth-1:0];
                n_first = 1'b1;
                n_cnt   = ChunkIdxW'(1);
                n_state = ST_MUL_SENS;
            end
            ST_SENS: begin
                n_sens  = w_sens_full[MulAWidth-1:0];
                n_first = 1'b1;
                n_cnt   = ChunkIdxW'(2);
                n_state = ST_MUL_P;
            end
            ST_P1: begin
                n_tmp   = w_p1;
                n_state = ST_P2;
            end
            ST_P2: begin
                n_res   = w_p_q[ValWidth-1:0];
                n_state = ST_DONE;
            end
            ST_HFIN: begin
                n_res   = w_h_q[ValWidth-1:0] - HumOffset;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_val   = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_first     <= 1'b0;
            r_dt        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_first     <= n_first;
            r_dt        <= n_dt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_raw      <= n_raw;
        r_off      <= n_off;
        r_sens     <= n_sens;
        r_tmp      <= n_tmp;
        r_res      <= n_res;
        r_out_kind <= n_out_kind;
        r_out_val  <= n_out_val;
    end

    assign o_out_valid         = r_out_valid;
    assign o_reading_kind      = r_out_kind;
    assign o_compensated_value = $signed(r_out_val);

    a_idle_no_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_mac_ctl.step)
        else $error("multiplier stepped while idle");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_dt_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DT) |=> $stable(r_dt))
        else $error("kept dT changed outside a temperature item");

endmodule

`default_nettype wire
